### src/sri_pkg.sv
// ----------------------------------------------------------------------------
// sri_pkg: shared widths and types for the segment/rectangle crossing pipe
// Coordinate widths, derived arithmetic widths and the sideband record that
// travels with an item through the divider.
// ----------------------------------------------------------------------------
package sri_pkg;
	localparam int CB  = 20;        // coordinate bits
	localparam int DW  = CB + 1;    // segment delta / edge coordinate
	localparam int NW  = CB + 2;    // offsets against an edge
	localparam int HW  = CB - 2;    // half size
	localparam int LW  = CB - 1;    // full edge length
	localparam int RW  = CB;        // |delta| and divider remainder
	localparam int QB  = CB + 1;    // quotient bits
	localparam int PW  = NW + DW;   // signed product width
	localparam int MW  = QB + RW;   // dividend magnitude bits
	localparam int LDW = LW + RW;   // edge length times |delta|
	localparam int NE  = 4;         // edges: left, right, top, bottom

	typedef struct packed {
		logic                 hit;
		logic                 vert;
		logic                 neg;
		logic signed [CB-1:0] b1;
		logic signed [CB-1:0] c;
	} side_t;
endpackage

### src/sri_div.sv
// ----------------------------------------------------------------------------
// sri_div: pipelined restoring divider
// One quotient bit per stage; the sideband record rides along with each item.
// ----------------------------------------------------------------------------
module sri_div (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       en,
	input  logic                       in_valid,
	input  logic [sri_pkg::MW-1:0]     in_mag,
	input  logic [sri_pkg::RW-1:0]     in_den,
	input  sri_pkg::side_t             in_side,
	output logic                       out_valid,
	output logic [sri_pkg::QB-1:0]     out_quo,
	output sri_pkg::side_t             out_side
);
	import sri_pkg::*;

	logic          v_s   [QB];
	logic [RW-1:0] rem_s [QB];
	logic [QB-1:0] alo_s [QB];
	logic [QB-1:0] quo_s [QB];
	logic [RW-1:0] den_s [QB];
	side_t         side_s[QB];

	genvar k;
	generate
		for (k = 0; k < QB; k++) begin : g_stage
			logic          v_in;
			logic [RW-1:0] rem_in;
			logic [QB-1:0] alo_in;
			logic [QB-1:0] quo_in;
			logic [RW-1:0] den_in;
			side_t         side_in;
			logic [RW:0]   trial;
			logic          take;

			if (k == 0) begin : g_first
				assign v_in    = in_valid;
				assign rem_in  = in_mag[MW-1:QB];
				assign alo_in  = in_mag[QB-1:0];
				assign quo_in  = '0;
				assign den_in  = in_den;
				assign side_in = in_side;
			end else begin : g_next
				assign v_in    = v_s[k-1];
				assign rem_in  = rem_s[k-1];
				assign alo_in  = alo_s[k-1];
				assign quo_in  = quo_s[k-1];
				assign den_in  = den_s[k-1];
				assign side_in = side_s[k-1];
			end

			assign trial = {rem_in, alo_in[QB-1]};
			assign take  = trial >= {1'b0, den_in};

			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					v_s[k] <= 1'b0;
				end else if (en) begin
					v_s[k] <= v_in;
				end
			end

			always_ff @(posedge clk) begin
				if (en) begin
					rem_s[k]  <= take ? RW'(trial - {1'b0, den_in}) : trial[RW-1:0];
					alo_s[k]  <= {alo_in[QB-2:0], 1'b0};
					quo_s[k]  <= {quo_in[QB-2:0], take};
					den_s[k]  <= den_in;
					side_s[k] <= side_in;
				end
			end
		end
	endgenerate

	assign out_valid = v_s[QB-1];
	assign out_quo   = quo_s[QB-1];
	assign out_side  = side_s[QB-1];

	// remainder stays below the divisor once a nonzero divisor is in flight
	a_rem_bound: assert property (@(posedge clk) disable iff (!arst_n)
		v_s[QB-1] && den_s[QB-1] != '0 |-> rem_s[QB-1] < den_s[QB-1])
		else $error("divider remainder out of range");
	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		v_s[QB-1] && !side_s[QB-1].hit |-> quo_s[QB-1] == '0)
		else $error("miss produced a nonzero quotient");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!en |=> $stable(quo_s[QB-1]) && $stable(v_s[QB-1]))
		else $error("divider moved while stalled");
endmodule

### src/segment_rectangle_intersect_top.sv
// ----------------------------------------------------------------------------
// segment_rectangle_intersect_top: segment versus rectangle edge crossing
// Finds the first of the left, right, top and bottom edges that a segment
// crosses and returns the crossing point, fully pipelined.
// ----------------------------------------------------------------------------
// The block takes one query per clock while the output is not stalled
// and returns exactly one result per query, in order. The divider
// produces one quotient bit per stage. A stall at the output freezes the
// whole pipe; in_ready is high whenever the output register is empty or
// being drained, so a new query enters in the same cycle that a finished
// result leaves.
module segment_rectangle_intersect_top (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic signed [sri_pkg::CB-1:0]     seg_start_x,
	input  logic signed [sri_pkg::CB-1:0]     seg_start_y,
	input  logic signed [sri_pkg::CB-1:0]     seg_end_x,
	input  logic signed [sri_pkg::CB-1:0]     seg_end_y,
	input  logic signed [sri_pkg::CB-1:0]     box_center_x,
	input  logic signed [sri_pkg::CB-1:0]     box_center_y,
	input  logic        [sri_pkg::CB-2:0]     box_width,
	input  logic        [sri_pkg::CB-2:0]     box_height,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic                              hit,
	output logic signed [sri_pkg::CB-1:0]     hit_x,
	output logic signed [sri_pkg::CB-1:0]     hit_y
);
	import sri_pkg::*;

	// advance every stage together unless a finished result is held
	logic en;
	assign en       = !out_valid || out_ready;
	assign in_ready = en;

	// ---------------- stage 1: edge coordinates and segment deltas ----------
	logic                 v_s1;
	logic signed [CB-1:0] x1_s1, y1_s1;
	logic signed [DW-1:0] dx_s1, dy_s1, lx_s1, rx_s1, ty_s1, by_s1;
	logic        [HW-1:0] hw_s1, hh_s1;
	logic        [HW-1:0] hw, hh;

	assign hw = box_width[CB-2:1];
	assign hh = box_height[CB-2:1];

	always_ff @(posedge clk) begin
		if (en) begin
			x1_s1 <= seg_start_x;
			y1_s1 <= seg_start_y;
			dx_s1 <= DW'(seg_end_x) - DW'(seg_start_x);
			dy_s1 <= DW'(seg_end_y) - DW'(seg_start_y);
			lx_s1 <= DW'(box_center_x) - DW'($signed({1'b0, hw}));
			rx_s1 <= DW'(box_center_x) + DW'($signed({1'b0, hw}));
			ty_s1 <= DW'(box_center_y) + DW'($signed({1'b0, hh}));
			by_s1 <= DW'(box_center_y) - DW'($signed({1'b0, hh}));
			hw_s1 <= hw;
			hh_s1 <= hh;
		end
	end

	// ---------------- stage 2: per-edge offsets ------------------------------
	// Each edge sits at a fixed coordinate c on axis a and spans [lo, lo+L]
	// on axis b. With D = |da| and N the signed distance to the edge along
	// the segment's direction, the crossing parameter is t = N / D.
	logic                 v_s2;
	logic signed [NW-1:0] n_s2  [NE];
	logic        [RW-1:0] d_s2  [NE];
	logic signed [NW-1:0] r_s2  [NE];
	logic        [LW-1:0] l_s2  [NE];
	logic                 ok_s2 [NE];
	logic signed [DW-1:0] db_s2 [NE];
	logic signed [CB-1:0] b1_s2 [NE];
	logic signed [DW-1:0] c_s2  [NE];

	logic signed [DW-1:0] c_e  [NE];
	logic signed [CB-1:0] a1_e [NE];
	logic signed [DW-1:0] da_e [NE];
	logic signed [DW-1:0] db_e [NE];
	logic signed [CB-1:0] b1_e [NE];
	logic signed [DW-1:0] lo_e [NE];
	logic        [HW-1:0] h_e  [NE];

	always_comb begin
		for (int e = 0; e < NE; e++) begin
			if (e < 2) begin
				c_e[e]  = (e == 0) ? lx_s1 : rx_s1;
				a1_e[e] = x1_s1;
				da_e[e] = dx_s1;
				db_e[e] = dy_s1;
				b1_e[e] = y1_s1;
				lo_e[e] = by_s1;
				h_e[e]  = hh_s1;
			end else begin
				c_e[e]  = (e == 2) ? ty_s1 : by_s1;
				a1_e[e] = y1_s1;
				da_e[e] = dy_s1;
				db_e[e] = dx_s1;
				b1_e[e] = x1_s1;
				lo_e[e] = lx_s1;
				h_e[e]  = hw_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int e = 0; e < NE; e++) begin
				n_s2[e]  <= da_e[e][DW-1] ? NW'(a1_e[e]) - NW'(c_e[e])
				                          : NW'(c_e[e]) - NW'(a1_e[e]);
				d_s2[e]  <= da_e[e][DW-1] ? RW'(-da_e[e]) : RW'(da_e[e]);
				r_s2[e]  <= NW'(b1_e[e]) - NW'(lo_e[e]);
				l_s2[e]  <= {h_e[e], 1'b0};
				ok_s2[e] <= (h_e[e] != '0) && (da_e[e] != '0);
				db_s2[e] <= db_e[e];
				b1_s2[e] <= b1_e[e];
				c_s2[e]  <= c_e[e];
			end
		end
	end

	// ---------------- stage 3: products ------------------------------------
	logic                  v_s3;
	logic signed [PW-1:0]  p1_s3 [NE];
	logic signed [PW-1:0]  p2_s3 [NE];
	logic        [LDW-1:0] p3_s3 [NE];
	logic                  ok_s3 [NE];
	logic signed [NW-1:0]  n_s3  [NE];
	logic        [RW-1:0]  d_s3  [NE];
	logic signed [DW-1:0]  db_s3 [NE];
	logic signed [CB-1:0]  b1_s3 [NE];
	logic signed [DW-1:0]  c_s3  [NE];

	always_ff @(posedge clk) begin
		if (en) begin
			for (int e = 0; e < NE; e++) begin
				p1_s3[e] <= PW'(r_s2[e] * $signed({1'b0, d_s2[e]}));
				p2_s3[e] <= PW'(n_s2[e] * db_s2[e]);
				p3_s3[e] <= LDW'(l_s2[e] * d_s2[e]);
				// t must lie in [0, 1]
				ok_s3[e] <= ok_s2[e] && !n_s2[e][NW-1]
				            && (n_s2[e] <= $signed({2'b00, d_s2[e]}));
				n_s3[e]  <= n_s2[e];
				d_s3[e]  <= d_s2[e];
				db_s3[e] <= db_s2[e];
				b1_s3[e] <= b1_s2[e];
				c_s3[e]  <= c_s2[e];
			end
		end
	end

	// ---------------- stage 4: range check and edge priority ---------------
	// The point's offset along the edge, scaled by D, must lie in [0, L*D].
	logic                 v_s4;
	logic                 hit_s4;
	logic                 vert_s4;
	logic signed [NW-1:0] n_s4;
	logic        [RW-1:0] d_s4;
	logic signed [DW-1:0] db_s4;
	logic signed [CB-1:0] b1_s4;
	logic signed [DW-1:0] c_s4;

	logic signed [PW:0]   m_e   [NE];
	logic                 hit_e [NE];
	logic                 sel_hit, sel_vert;
	logic signed [NW-1:0] sel_n;
	logic        [RW-1:0] sel_d;
	logic signed [DW-1:0] sel_db;
	logic signed [CB-1:0] sel_b1;
	logic signed [DW-1:0] sel_c;

	always_comb begin
		for (int e = 0; e < NE; e++) begin
			m_e[e]   = (PW+1)'(p1_s3[e]) + (PW+1)'(p2_s3[e]);
			hit_e[e] = ok_s3[e] && !m_e[e][PW]
			           && (m_e[e] <= $signed({{(PW+1-LDW){1'b0}}, p3_s3[e]}));
		end
		// a miss divides zero by one
		sel_hit  = 1'b0;
		sel_vert = 1'b0;
		sel_n    = '0;
		sel_d    = RW'(1);
		sel_db   = '0;
		sel_b1   = '0;
		sel_c    = '0;
		// scan from the lowest priority so the first edge wins
		for (int e = NE - 1; e >= 0; e--) begin
			if (hit_e[e]) begin
				sel_hit  = 1'b1;
				sel_vert = (e < 2);
				sel_n    = n_s3[e];
				sel_d    = d_s3[e];
				sel_db   = db_s3[e];
				sel_b1   = b1_s3[e];
				sel_c    = c_s3[e];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			hit_s4  <= sel_hit;
			vert_s4 <= sel_vert;
			n_s4    <= sel_n;
			d_s4    <= sel_d;
			db_s4   <= sel_db;
			b1_s4   <= sel_b1;
			c_s4    <= sel_c;
		end
	end

	// ---------------- stage 5: dividend N * db -----------------------------
	logic                 v_s5;
	logic        [MW-1:0] mag_s5;
	logic        [RW-1:0] d_s5;
	side_t                side_s5;
	logic signed [PW-1:0] prod;
	logic        [PW-1:0] prod_abs;

	assign prod     = PW'(n_s4 * db_s4);
	assign prod_abs = prod[PW-1] ? PW'(-prod) : PW'(prod);

	always_ff @(posedge clk) begin
		if (en) begin
			mag_s5       <= prod_abs[MW-1:0];
			d_s5         <= d_s4;
			side_s5.hit  <= hit_s4;
			side_s5.vert <= vert_s4;
			side_s5.neg  <= prod[PW-1];
			side_s5.b1   <= b1_s4;
			side_s5.c    <= c_s4[CB-1:0];
		end
	end

	// valid bits for the front stages
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
		end
	end

	// ---------------- divider: trunc(|N*db| / D) ---------------------------
	logic          dv_valid;
	logic [QB-1:0] dv_quo;
	side_t         dv_side;

	sri_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (v_s5),
		.in_mag    (mag_s5),
		.in_den    (d_s5),
		.in_side   (side_s5),
		.out_valid (dv_valid),
		.out_quo   (dv_quo),
		.out_side  (dv_side)
	);

	// ---------------- output register ---------------------------------------
	// The crossing sits at c on the edge's own axis and at b1 + quotient on
	// the other one.
	logic signed [QB-1:0] quo_sgn;
	logic signed [CB-1:0] coord;

	assign quo_sgn = dv_side.neg ? QB'(-dv_quo) : QB'(dv_quo);
	assign coord   = dv_side.b1 + quo_sgn[CB-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (en) begin
			out_valid <= dv_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			hit <= dv_side.hit;
			if (!dv_side.hit) begin
				hit_x <= '0;
				hit_y <= '0;
			end else if (dv_side.vert) begin
				hit_x <= dv_side.c;
				hit_y <= coord;
			end else begin
				hit_x <= coord;
				hit_y <= dv_side.c;
			end
		end
	end

	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !hit |-> hit_x == '0 && hit_y == '0)
		else $error("miss reported with a nonzero point");
	a_stall_block: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |-> !in_ready)
		else $error("input taken while output is stalled");
	a_drain: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(out_valid) |-> $past(out_ready))
		else $error("result dropped without a transaction");
endmodule

### tb/segment_rectangle_intersect_top_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// segment_rectangle_intersect_top_test: crossing-point checks for the pipe
// Drives segment/rectangle queries with random idling on both channels,
// predicts the first edge crossing with exact wide integer arithmetic and
// compares every result, in order, with the predicted one.
// ----------------------------------------------------------------------------
module segment_rectangle_intersect_top_test;
	import sri_pkg::*;

	localparam int WATCHDOG_CYCLES = 20000;
	localparam int DRAIN_CYCLES    = 60;

	typedef struct packed {
		logic                 hit;
		logic signed [CB-1:0] x;
		logic signed [CB-1:0] y;
	} crossing_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic signed [CB-1:0] seg_start_x = '0, seg_start_y = '0;
	logic signed [CB-1:0] seg_end_x = '0, seg_end_y = '0;
	logic signed [CB-1:0] box_center_x = '0, box_center_y = '0;
	logic [CB-2:0] box_width = '0, box_height = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic hit;
	logic signed [CB-1:0] hit_x, hit_y;

	crossing_t expected_crossings[$];
	int mismatch_count = 0;
	int idle_cycles = 0;
	bit allow_idling = 1'b1;

	always #4 clk = ~clk;

	segment_rectangle_intersect_top dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.seg_start_x(seg_start_x), .seg_start_y(seg_start_y),
		.seg_end_x(seg_end_x), .seg_end_y(seg_end_y),
		.box_center_x(box_center_x), .box_center_y(box_center_y),
		.box_width(box_width), .box_height(box_height),
		.out_valid(out_valid), .out_ready(out_ready),
		.hit(hit), .hit_x(hit_x), .hit_y(hit_y)
	);

	task automatic report_mismatch(input string what);
		$display("MISMATCH at %0t: %s", $realtime, what);
		mismatch_count++;
	endtask

	// Divide truncating toward zero; den is nonzero.
	function automatic longint div_toward_zero(input longint num, input longint den);
		longint q;
		q = (num < 0 ? -num : num) / (den < 0 ? -den : den);
		return ((num < 0) != (den < 0)) ? -q : q;
	endfunction

	// Parametric test of the segment against one edge; fills px/py on a hit.
	function automatic bit edge_crossing(input longint x1, y1, x2, y2,
			input longint x3, y3, x4, y4, output longint px, output longint py);
		longint dx, dy, ex, ey, ox, oy, den, na, nb;
		dx = x2 - x1; dy = y2 - y1;
		ex = x4 - x3; ey = y4 - y3;
		ox = x1 - x3; oy = y1 - y3;
		den = ey * dx - ex * dy;
		na = ex * oy - ey * ox;
		nb = dx * oy - dy * ox;
		px = 0; py = 0;
		if (den == 0) return 1'b0;
		if (den < 0) begin
			den = -den; na = -na; nb = -nb;
		end
		if (na < 0 || na > den || nb < 0 || nb > den) return 1'b0;
		px = x1 + div_toward_zero(na * dx, den);
		py = y1 + div_toward_zero(na * dy, den);
		return 1'b1;
	endfunction

	function automatic crossing_t first_crossing(input longint sx, sy, ex, ey,
			input longint cx, cy, input longint w, h);
		longint hw, hh, lx, rx, ty, by, px, py;
		bit found;
		crossing_t r;
		hw = w >>> 1; hh = h >>> 1;
		lx = cx - hw; rx = cx + hw; ty = cy + hh; by = cy - hh;
		found = edge_crossing(sx, sy, ex, ey, lx, ty, lx, by, px, py);
		if (!found) found = edge_crossing(sx, sy, ex, ey, rx, ty, rx, by, px, py);
		if (!found) found = edge_crossing(sx, sy, ex, ey, lx, ty, rx, ty, px, py);
		if (!found) found = edge_crossing(sx, sy, ex, ey, lx, by, rx, by, px, py);
		r.hit = found;
		r.x = found ? px[CB-1:0] : '0;
		r.y = found ? py[CB-1:0] : '0;
		return r;
	endfunction

	// Send one query; predict its result once the transaction is accepted.
	// Valid drops only for an idle burst, so back-to-back queries keep it high.
	task automatic send_query(input logic signed [CB-1:0] sx, sy, ex, ey, cx, cy,
			input logic [CB-2:0] w, h);
		int gap;
		if (allow_idling && $urandom_range(0, 3) == 0) begin
			gap = $urandom_range(1, 14);
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		seg_start_x <= sx; seg_start_y <= sy; seg_end_x <= ex; seg_end_y <= ey;
		box_center_x <= cx; box_center_y <= cy; box_width <= w; box_height <= h;
		in_valid <= 1'b1;
		do @(posedge clk); while (!in_ready);
		expected_crossings.push_back(first_crossing(sx, sy, ex, ey, cx, cy, w, h));
		@(negedge clk);
	endtask

	// Output side: random stall bursts, compare each result transaction.
	initial begin
		crossing_t exp_c;
		int stall;
		forever begin
			@(negedge clk);
			if (allow_idling && $urandom_range(0, 3) == 0) begin
				stall = $urandom_range(1, 14);
				out_ready <= 1'b0;
				repeat (stall) @(negedge clk);
			end
			out_ready <= 1'b1;
			@(posedge clk);
			if (arst_n && out_valid && out_ready) begin
				if (expected_crossings.size() == 0) begin
					report_mismatch("result with nothing expected");
				end else begin
					exp_c = expected_crossings.pop_front();
					if (hit !== exp_c.hit)
						report_mismatch($sformatf("hit %b, want %b", hit, exp_c.hit));
					if (hit_x !== exp_c.x)
						report_mismatch($sformatf("hit_x %0d, want %0d", hit_x, exp_c.x));
					if (hit_y !== exp_c.y)
						report_mismatch($sformatf("hit_y %0d, want %0d", hit_y, exp_c.y));
				end
			end
		end
	end

	// Watchdog: count cycles without any transaction on either channel.
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || !arst_n)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_CYCLES) begin
			$display("Mismatches found");
			$finish;
		end
	end

	function automatic logic signed [CB-1:0] rand_coord();
		return CB'($urandom);
	endfunction

	function automatic logic signed [CB-1:0] near(input logic signed [CB-1:0] c,
			input int span);
		return c + CB'($urandom_range(0, 2 * span) - span);
	endfunction

	task automatic test_extremes();
		logic signed [CB-1:0] mx, mn;
		mx = {1'b0, {(CB-1){1'b1}}};
		mn = {1'b1, {(CB-1){1'b0}}};
		send_query(mn, mn, mx, mx, '0, '0, '1, '1);
		send_query(mx, mn, mn, mx, '0, '0, '1, '1);
		send_query(mn, 0, mx, 0, mx, mn, '1, '1);
		send_query(mx, mx, mn, mn, mn, mx, '1, '1);
		send_query(mn, mn, mn, mn, mn, mn, '0, '0);
		send_query(mx, mx, mx, mx, mx, mx, '1, '1);
	endtask

	task automatic test_each_edge();
		// Hit left, right, top and bottom alone; crossing on the segment
		// ends and on the edge corners.
		send_query(-1000, 10, -200, 10, 0, 0, 512, 512);
		send_query(1000, 10, 200, 10, 0, 0, 512, 512);
		send_query(5, 1000, 5, 200, 0, 0, 512, 512);
		send_query(5, -1000, 5, -200, 0, 0, 512, 512);
		send_query(-256, 0, -300, 0, 0, 0, 512, 512);
		send_query(-256, 256, -400, 400, 0, 0, 512, 512);
		send_query(-300, 256, 300, 256, 0, 0, 512, 512);
		send_query(-400, -100, 400, 100, 0, 0, 512, 512);
		send_query(-400, -401, 400, 401, 0, 0, 513, 257);
	endtask

	task automatic test_degenerate();
		// Zero-length segment, zero half sizes, parallel miss, clean miss.
		send_query(0, 0, 0, 0, 0, 0, 512, 512);
		send_query(-1000, 0, 1000, 0, 0, 0, 1, 1);
		send_query(-1000, 0, 1000, 0, 0, 0, 0, 600);
		send_query(-1000, 600, 1000, 600, 0, 0, 512, 512);
		send_query(-100, 0, 100, 0, 0, 0, 512, 512);
		send_query(1000, 1000, 2000, 3000, 0, 0, 512, 512);
	endtask

	task automatic test_random(input int count);
		logic signed [CB-1:0] sx, sy, ex, ey, cx, cy;
		logic [CB-2:0] w, h;
		int span;
		for (int i = 0; i < count; i++) begin
			cx = rand_coord(); cy = rand_coord();
			w = (CB-1)'($urandom); h = (CB-1)'($urandom);
			case ($urandom_range(0, 3))
				0: begin
					// full-range noise
					sx = rand_coord(); sy = rand_coord();
					ex = rand_coord(); ey = rand_coord();
				end
				default: begin
					// segments around the box so that edges get crossed
					span = $urandom_range(0, 1) ? 400 : 200000;
					w = (CB-1)'($urandom_range(0, 2 * span));
					h = (CB-1)'($urandom_range(0, 2 * span));
					sx = near(cx, 2 * span); sy = near(cy, 2 * span);
					ex = near(cx, 2 * span); ey = near(cy, 2 * span);
					if ($urandom_range(0, 7) == 0) ey = sy;
					if ($urandom_range(0, 7) == 0) ex = sx;
				end
			endcase
			send_query(sx, sy, ex, ey, cx, cy, w, h);
		end
	endtask

	initial begin
		repeat (5) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		test_extremes();
		test_each_edge();
		test_degenerate();
		test_random(1300);
		// last stretch back to back, no idling on either side
		allow_idling = 1'b0;
		test_random(330);
		in_valid <= 1'b0;
		while (expected_crossings.size() != 0) @(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
		if (mismatch_count == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end
endmodule

### sim.f
src/sri_pkg.sv
src/sri_div.sv
src/segment_rectangle_intersect_top.sv
tb/segment_rectangle_intersect_top_test.sv
